FILE: hw/rtl/qat_pkg.sv
// Shared types, codes and sizes for the quoted argument tokenizer.
package qat_pkg;

  // Default line length; positions count modulo this value.
  localparam int unsigned QAT_MAX_LINE = 4096;

  // Depth of the event queue between the front and back parts.
  localparam int unsigned QAT_EVQ_DEPTH = 4;

  // Width of the reported position fields.
  localparam int unsigned POS_OUT_W = 12;

  // Byte values that the scanner recognizes.
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DQUOTE = 8'd34;
  localparam logic [7:0] CH_SQUOTE = 8'd39;

  // Result kinds.
  localparam logic [2:0] KIND_TOKEN          = 3'd0;
  localparam logic [2:0] KIND_DONE_OK        = 3'd1;
  localparam logic [2:0] KIND_DONE_EMPTY     = 3'd2;
  localparam logic [2:0] KIND_UNCLOSED_SINGLE = 3'd3;
  localparam logic [2:0] KIND_UNCLOSED_DOUBLE = 3'd4;
  localparam logic [2:0] KIND_EMPTY_SINGLE   = 3'd5;
  localparam logic [2:0] KIND_EMPTY_DOUBLE   = 3'd6;

  // One classified byte: an optional token followed by an optional closing result.
  typedef struct packed {
    logic                 tok_v;
    logic [POS_OUT_W-1:0] tok_start;
    logic [POS_OUT_W-1:0] tok_end;
    logic                 tail_v;
    logic [2:0]           tail_kind;
  } qat_evt_t;

endpackage

FILE: hw/rtl/quoted_argument_tokenizer_unit.sv
// Top level of the quoted argument tokenizer: front scanner, event queue, result stage.
// Throughput: one byte per cycle while the event queue has room; a byte that closes a
//   token and the line yields two result items, the token first and then the closing result.
// Path: the event is written into the event queue when its byte is accepted, and the result
//   register loads from the queue head when it is free or being popped.
// Reset (synchronous, rst_n low): line state, event queue pointers and result valid flag clear.
module quoted_argument_tokenizer_unit
  import qat_pkg::*;
#(
  parameter int unsigned MAX_LINE  = QAT_MAX_LINE,
  parameter int unsigned EVQ_DEPTH = QAT_EVQ_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           in_char_byte,
  output logic                 empty,
  input  logic                 pop,
  output logic [2:0]           out_kind,
  output logic [POS_OUT_W-1:0] out_token_start,
  output logic [POS_OUT_W-1:0] out_token_end,
  output logic                 out_last
);

  logic     byte_v;
  logic     fr_evt_v;
  qat_evt_t fr_evt;
  logic     q_v;
  qat_evt_t q_evt;
  logic     q_pop;

  // A byte is taken only while the event queue has room for its event.
  assign byte_v = push && !full;

  qat_front #(
    .MAX_LINE (MAX_LINE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_v    (byte_v),
    .char_byte (in_char_byte),
    .evt_v     (fr_evt_v),
    .evt       (fr_evt)
  );

  qat_evq #(
    .DEPTH (EVQ_DEPTH)
  ) u_evq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_v    (fr_evt_v),
    .wr_data (fr_evt),
    .full    (full),
    .rd_pop  (q_pop),
    .rd_v    (q_v),
    .rd_data (q_evt)
  );

  qat_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .evt_v       (q_v),
    .evt         (q_evt),
    .evt_pop     (q_pop),
    .empty       (empty),
    .pop         (pop),
    .kind        (out_kind),
    .token_start (out_token_start),
    .token_end   (out_token_end),
    .last        (out_last)
  );

endmodule

FILE: hw/rtl/qat_front.sv
// Front part: scans line bytes, tracks word state and emits classified events.
module qat_front
  import qat_pkg::*;
#(
  parameter int unsigned MAX_LINE = QAT_MAX_LINE
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_v,
  input  logic [7:0] char_byte,
  output logic       evt_v,
  output qat_evt_t   evt
);

  localparam int unsigned PW = $clog2(MAX_LINE);
  localparam logic [PW-1:0] POS_LAST = PW'(MAX_LINE - 1);

  // Scanner modes.
  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_PLAIN  = 3'd1;
  localparam logic [2:0] MODE_SINGLE = 3'd2;
  localparam logic [2:0] MODE_DOUBLE = 3'd3;
  localparam logic [2:0] MODE_SKIP   = 3'd4;

  logic [2:0]    mode_r, mode_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] ws_r, ws_nxt;
  logic          sodd_r, sodd_nxt;
  logic          dodd_r, dodd_nxt;
  logic          any_r, any_nxt;

  logic [PW-1:0] pos_inc;
  logic [PW-1:0] pos_dec;
  logic [PW+POS_OUT_W-1:0] ws_ext;
  logic [PW+POS_OUT_W-1:0] dec_ext;
  logic          white;
  logic          is_quote;

  // Wrapping neighbors of the current position.
  assign pos_inc = (pos_r == POS_LAST) ? '0 : pos_r + 1'b1;
  assign pos_dec = (pos_r == '0) ? POS_LAST : pos_r - 1'b1;
  assign ws_ext  = {{POS_OUT_W{1'b0}}, ws_r};
  assign dec_ext = {{POS_OUT_W{1'b0}}, pos_dec};
  assign white   = (char_byte == CH_TAB) || (char_byte == CH_SPACE);
  assign is_quote = (mode_r == MODE_SINGLE) ? (char_byte == CH_SQUOTE)
                                            : (char_byte == CH_DQUOTE);

  // Next state and event for one accepted byte.
  always_comb begin
    mode_nxt = mode_r;
    pos_nxt  = pos_r;
    ws_nxt   = ws_r;
    sodd_nxt = sodd_r;
    dodd_nxt = dodd_r;
    any_nxt  = any_r;
    evt           = '0;
    evt.tok_start = ws_ext[POS_OUT_W-1:0];
    evt.tok_end   = dec_ext[POS_OUT_W-1:0];
    if (byte_v) begin
      pos_nxt = pos_inc;
      if (char_byte == CH_NUL) begin
        // The terminator closes the open word and reports the line, unless an error already ended it.
        unique case (mode_r)
          MODE_PLAIN: begin
            evt.tail_v = 1'b1;
            if (sodd_r) begin
              evt.tail_kind = KIND_UNCLOSED_SINGLE;
            end else if (dodd_r) begin
              evt.tail_kind = KIND_UNCLOSED_DOUBLE;
            end else begin
              evt.tok_v     = 1'b1;
              evt.tail_kind = KIND_DONE_OK;
            end
          end
          MODE_SINGLE: begin
            evt.tail_v    = 1'b1;
            evt.tail_kind = KIND_UNCLOSED_SINGLE;
          end
          MODE_DOUBLE: begin
            evt.tail_v    = 1'b1;
            evt.tail_kind = KIND_UNCLOSED_DOUBLE;
          end
          MODE_SKIP: begin
          end
          default: begin
            evt.tail_v    = 1'b1;
            evt.tail_kind = any_r ? KIND_DONE_OK : KIND_DONE_EMPTY;
          end
        endcase
        mode_nxt = MODE_IDLE;
        pos_nxt  = '0;
        ws_nxt   = '0;
        sodd_nxt = 1'b0;
        dodd_nxt = 1'b0;
        any_nxt  = 1'b0;
      end else begin
        unique case (mode_r)
          MODE_SKIP: begin
          end
          MODE_PLAIN: begin
            // A plain word ends at whitespace, with its quote parity checked.
            if (white) begin
              if (sodd_r) begin
                evt.tail_v    = 1'b1;
                evt.tail_kind = KIND_UNCLOSED_SINGLE;
                mode_nxt      = MODE_SKIP;
              end else if (dodd_r) begin
                evt.tail_v    = 1'b1;
                evt.tail_kind = KIND_UNCLOSED_DOUBLE;
                mode_nxt      = MODE_SKIP;
              end else begin
                evt.tok_v = 1'b1;
                any_nxt   = 1'b1;
                mode_nxt  = MODE_IDLE;
              end
            end else if (char_byte == CH_SQUOTE) begin
              sodd_nxt = ~sodd_r;
            end else if (char_byte == CH_DQUOTE) begin
              dodd_nxt = ~dodd_r;
            end
          end
          MODE_SINGLE, MODE_DOUBLE: begin
            // A quoted word ends at the matching quote.
            if (is_quote) begin
              if (pos_r == ws_r) begin
                evt.tail_v    = 1'b1;
                evt.tail_kind = (mode_r == MODE_SINGLE) ? KIND_EMPTY_SINGLE
                                                        : KIND_EMPTY_DOUBLE;
                mode_nxt      = MODE_SKIP;
              end else begin
                evt.tok_v = 1'b1;
                any_nxt   = 1'b1;
                mode_nxt  = MODE_IDLE;
              end
            end
          end
          default: begin
            // Between words: a non-separator byte opens a new word.
            mode_nxt = MODE_IDLE;
            if (!white) begin
              sodd_nxt = 1'b0;
              dodd_nxt = 1'b0;
              if (char_byte == CH_SQUOTE) begin
                mode_nxt = MODE_SINGLE;
                ws_nxt   = pos_inc;
              end else if (char_byte == CH_DQUOTE) begin
                mode_nxt = MODE_DOUBLE;
                ws_nxt   = pos_inc;
              end else begin
                mode_nxt = MODE_PLAIN;
                ws_nxt   = pos_r;
              end
            end
          end
        endcase
      end
    end
  end

  assign evt_v = byte_v && (evt.tok_v || evt.tail_v);

  // Line state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      pos_r  <= '0;
      ws_r   <= '0;
      sodd_r <= 1'b0;
      dodd_r <= 1'b0;
      any_r  <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      ws_r   <= ws_nxt;
      sodd_r <= sodd_nxt;
      dodd_r <= dodd_nxt;
      any_r  <= any_nxt;
    end
  end

endmodule

FILE: hw/rtl/qat_evq.sv
// Event queue: a small register FIFO between the front and back parts.
module qat_evq
  import qat_pkg::*;
#(
  parameter int unsigned DEPTH = QAT_EVQ_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_v,
  input  qat_evt_t wr_data,
  output logic     full,
  input  logic     rd_pop,
  output logic     rd_v,
  output qat_evt_t rd_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  qat_evt_t      mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr;
  logic          do_rd;

  assign full    = (cnt_r == CNT_FULL);
  assign rd_v    = (cnt_r != '0);
  assign rd_data = mem_r[rp_r];
  assign do_wr   = wr_v && !full;
  assign do_rd   = rd_pop && rd_v;

  // Pointer and fill count update.
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
    end
    if (do_rd) begin
      rp_nxt = (rp_r == PTR_LAST) ? '0 : rp_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_wr && do_rd) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

FILE: hw/rtl/qat_back.sv
// Back part: expands events into result items and holds them in an output register.
module qat_back
  import qat_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 evt_v,
  input  qat_evt_t             evt,
  output logic                 evt_pop,
  output logic                 empty,
  input  logic                 pop,
  output logic [2:0]           kind,
  output logic [POS_OUT_W-1:0] token_start,
  output logic [POS_OUT_W-1:0] token_end,
  output logic                 last
);

  logic                 out_v_r, out_v_nxt;
  logic                 phase_r, phase_nxt;
  logic [2:0]           kind_r;
  logic [POS_OUT_W-1:0] start_r;
  logic [POS_OUT_W-1:0] end_r;
  logic                 last_r;
  logic                 taken;
  logic                 load;
  logic                 send_tok;
  logic                 head_done;

  // The token of an event goes out before its closing result.
  assign taken     = pop && out_v_r;
  assign load      = evt_v && (!out_v_r || taken);
  assign send_tok  = evt.tok_v && !phase_r;
  assign head_done = !send_tok || !evt.tail_v;
  assign evt_pop   = load && head_done;

  always_comb begin
    out_v_nxt = out_v_r;
    phase_nxt = phase_r;
    if (load) begin
      out_v_nxt = 1'b1;
      phase_nxt = !head_done;
    end else if (taken) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      phase_r <= phase_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= send_tok ? KIND_TOKEN : evt.tail_kind;
      start_r <= send_tok ? evt.tok_start : '0;
      end_r   <= send_tok ? evt.tok_end : '0;
      last_r  <= !send_tok;
    end
  end

  assign empty       = !out_v_r;
  assign kind        = kind_r;
  assign token_start = start_r;
  assign token_end   = end_r;
  assign last        = last_r;

endmodule

FILE: verif/qat_result_checker.sv
// Result checker for the quoted argument tokenizer: predicts each result item and compares.
module qat_result_checker
  import qat_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic                 full,
  input  logic [7:0]           in_char_byte,
  input  logic                 empty,
  input  logic                 pop,
  input  logic [2:0]           out_kind,
  input  logic [POS_OUT_W-1:0] out_token_start,
  input  logic [POS_OUT_W-1:0] out_token_end,
  input  logic                 out_last,
  output int                   fail_count,
  output int                   pending
);

  // Scanner modes of the line being tokenized.
  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_PLAIN,
    SCAN_SINGLE,
    SCAN_DOUBLE,
    SCAN_SKIP
  } scan_mode_t;

  typedef struct packed {
    logic [2:0]           kind;
    logic [POS_OUT_W-1:0] tok_start;
    logic [POS_OUT_W-1:0] tok_stop;
    logic                 last;
  } tok_result_t;

  tok_result_t          awaited_results[$];
  scan_mode_t           scan_mode;
  logic [POS_OUT_W-1:0] line_pos;
  logic [POS_OUT_W-1:0] word_start;
  logic                 single_odd;
  logic                 double_odd;
  logic                 any_token;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fail_count++;
  endtask

  function automatic void add_awaited(input logic [2:0] kind, input logic [POS_OUT_W-1:0] s,
                                      input logic [POS_OUT_W-1:0] e, input logic last);
    tok_result_t r;
    r.kind      = kind;
    r.tok_start = s;
    r.tok_stop  = e;
    r.last      = last;
    awaited_results.push_back(r);
  endfunction

  function automatic void clear_line();
    scan_mode  = SCAN_IDLE;
    line_pos   = '0;
    word_start = '0;
    single_odd = 1'b0;
    double_odd = 1'b0;
    any_token  = 1'b0;
  endfunction

  // Advance the line state by one byte and queue the result items it causes.
  // Positions are 12 bits wide, so they wrap at the line limit by themselves.
  function automatic void scan_byte(input logic [7:0] c);
    logic [POS_OUT_W-1:0] pos;
    logic [POS_OUT_W-1:0] prev;
    logic                 white;
    logic [7:0]           closer;
    pos    = line_pos;
    prev   = pos - 1'b1;
    white  = (c == CH_TAB) || (c == CH_SPACE);
    closer = (scan_mode == SCAN_SINGLE) ? CH_SQUOTE : CH_DQUOTE;

    // The terminator closes whatever is open and starts a new line.
    if (c == CH_NUL) begin
      case (scan_mode)
        SCAN_PLAIN: begin
          if (single_odd) begin
            add_awaited(KIND_UNCLOSED_SINGLE, '0, '0, 1'b1);
          end else if (double_odd) begin
            add_awaited(KIND_UNCLOSED_DOUBLE, '0, '0, 1'b1);
          end else begin
            add_awaited(KIND_TOKEN, word_start, prev, 1'b0);
            add_awaited(KIND_DONE_OK, '0, '0, 1'b1);
          end
        end
        SCAN_SINGLE: add_awaited(KIND_UNCLOSED_SINGLE, '0, '0, 1'b1);
        SCAN_DOUBLE: add_awaited(KIND_UNCLOSED_DOUBLE, '0, '0, 1'b1);
        SCAN_SKIP:   ;
        default: begin
          add_awaited(any_token ? KIND_DONE_OK : KIND_DONE_EMPTY, '0, '0, 1'b1);
        end
      endcase
      clear_line();
      return;
    end

    case (scan_mode)
      SCAN_SKIP: ;
      // A plain word ends at whitespace; odd quote counts turn it into an error.
      SCAN_PLAIN: begin
        if (white) begin
          if (single_odd) begin
            add_awaited(KIND_UNCLOSED_SINGLE, '0, '0, 1'b1);
            scan_mode = SCAN_SKIP;
          end else if (double_odd) begin
            add_awaited(KIND_UNCLOSED_DOUBLE, '0, '0, 1'b1);
            scan_mode = SCAN_SKIP;
          end else begin
            add_awaited(KIND_TOKEN, word_start, prev, 1'b0);
            any_token = 1'b1;
            scan_mode = SCAN_IDLE;
          end
        end else if (c == CH_SQUOTE) begin
          single_odd = ~single_odd;
        end else if (c == CH_DQUOTE) begin
          double_odd = ~double_odd;
        end
      end
      // Inside quotes only the matching quote matters.
      SCAN_SINGLE, SCAN_DOUBLE: begin
        if (c == closer) begin
          if (pos == word_start) begin
            add_awaited((scan_mode == SCAN_SINGLE) ? KIND_EMPTY_SINGLE : KIND_EMPTY_DOUBLE,
                        '0, '0, 1'b1);
            scan_mode = SCAN_SKIP;
          end else begin
            add_awaited(KIND_TOKEN, word_start, prev, 1'b0);
            any_token = 1'b1;
            scan_mode = SCAN_IDLE;
          end
        end
      end
      // Between words a non-blank byte opens a quoted or a plain word.
      default: begin
        scan_mode = SCAN_IDLE;
        if (!white) begin
          single_odd = 1'b0;
          double_odd = 1'b0;
          if (c == CH_SQUOTE) begin
            scan_mode  = SCAN_SINGLE;
            word_start = pos + 1'b1;
          end else if (c == CH_DQUOTE) begin
            scan_mode  = SCAN_DOUBLE;
            word_start = pos + 1'b1;
          end else begin
            scan_mode  = SCAN_PLAIN;
            word_start = pos;
          end
        end
      end
    endcase
    line_pos = pos + 1'b1;
  endfunction

  // Watch both channels: predict on each accepted item, compare each accepted result.
  always @(posedge clk) begin : watch
    tok_result_t want;
    if (!rst_n) begin
      clear_line();
      awaited_results.delete();
    end else begin
      if (push && !full) begin
        scan_byte(in_char_byte);
      end
      if (pop && !empty) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result kind %0d with nothing awaited", out_kind));
        end else begin
          want = awaited_results.pop_front();
          if (out_kind !== want.kind) begin
            report_mismatch($sformatf("kind %0d, expected %0d", out_kind, want.kind));
          end
          if (out_token_start !== want.tok_start) begin
            report_mismatch($sformatf("token_start %0d, expected %0d",
                                      out_token_start, want.tok_start));
          end
          if (out_token_end !== want.tok_stop) begin
            report_mismatch($sformatf("token_end %0d, expected %0d",
                                      out_token_end, want.tok_stop));
          end
          if (out_last !== want.last) begin
            report_mismatch($sformatf("last %0b, expected %0b", out_last, want.last));
          end
        end
      end
    end
    pending = awaited_results.size();
  end

endmodule

FILE: verif/tb_top.sv
// Testbench top for the quoted argument tokenizer: clock, reset, line stimulus and verdict.
module tb_top
  import qat_pkg::*;
();

  localparam int RANDOM_ITEMS = 1150;
  localparam int CYCLE_LIMIT  = 1000000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 push = 1'b0;
  logic [7:0]           in_char_byte = '0;
  logic                 pop = 1'b0;
  logic                 full;
  logic                 empty;
  logic [2:0]           out_kind;
  logic [POS_OUT_W-1:0] out_token_start;
  logic [POS_OUT_W-1:0] out_token_end;
  logic                 out_last;
  int                   fail_count;
  int                   pending;

  int                   cycles = 0;
  int                   pop_hold = 0;
  int                   bytes_sent = 0;
  logic [7:0]           line_bytes[$];

  quoted_argument_tokenizer_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_char_byte    (in_char_byte),
    .empty           (empty),
    .pop             (pop),
    .out_kind        (out_kind),
    .out_token_start (out_token_start),
    .out_token_end   (out_token_end),
    .out_last        (out_last)
  );

  qat_result_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_char_byte    (in_char_byte),
    .empty           (empty),
    .pop             (pop),
    .out_kind        (out_kind),
    .out_token_start (out_token_start),
    .out_token_end   (out_token_end),
    .out_last        (out_last),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Give up on a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: runs of pops and stalls, mostly short, a few long, some long free runs.
  always @(posedge clk) begin : pop_drive
    int r;
    if (!rst_n) begin
      pop      <= 1'b0;
      pop_hold <= 0;
    end else if (pop_hold != 0) begin
      pop_hold <= pop_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        pop      <= 1'b1;
        pop_hold <= $urandom_range(10, 60);
      end else if (r < 65) begin
        pop      <= 1'b1;
        pop_hold <= $urandom_range(0, 3);
      end else if (r < 92) begin
        pop      <= 1'b0;
        pop_hold <= $urandom_range(0, 2);
      end else begin
        pop      <= 1'b0;
        pop_hold <= $urandom_range(4, 20);
      end
    end
  end

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // A byte that is neither blank, quote nor terminator.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(1, 255));
    end while (b == CH_TAB || b == CH_SPACE || b == CH_SQUOTE || b == CH_DQUOTE);
    return b;
  endfunction

  // Offer one item and hold it until the block takes it.
  task automatic send_byte(input logic [7:0] b, input bit calm);
    int gap;
    gap = calm ? 0 : idle_cycles();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push         <= 1'b1;
    in_char_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
  endtask

  // Send the assembled line followed by its terminator.
  task automatic send_line(input bit calm);
    foreach (line_bytes[i]) send_byte(line_bytes[i], calm);
    send_byte(CH_NUL, calm);
    line_bytes.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endtask

  task automatic add_blanks(input int n);
    repeat (n) line_bytes.push_back($urandom_range(0, 1) ? CH_TAB : CH_SPACE);
  endtask

  // Mostly well-formed lines with random words; some broken words and some noise.
  task automatic build_random_line();
    int         nwords;
    int         r;
    bit         glued;
    bit         s_odd;
    bit         d_odd;
    logic [7:0] q;
    logic [7:0] b;
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 20)) line_bytes.push_back(8'($urandom_range(1, 255)));
      return;
    end
    nwords = $urandom_range(0, 5);
    if ($urandom_range(0, 2) == 0) add_blanks($urandom_range(1, 3));
    for (int w = 0; w < nwords; w++) begin
      r     = $urandom_range(0, 99);
      glued = 1'b0;
      if (r < 55) begin
        // Plain word, quotes inside it usually balanced.
        s_odd = 1'b0;
        d_odd = 1'b0;
        line_bytes.push_back(plain_byte());
        repeat ($urandom_range(0, 5)) begin
          r = $urandom_range(0, 99);
          if (r < 12) begin
            line_bytes.push_back(CH_SQUOTE);
            s_odd = ~s_odd;
          end else if (r < 22) begin
            line_bytes.push_back(CH_DQUOTE);
            d_odd = ~d_odd;
          end else begin
            line_bytes.push_back(plain_byte());
          end
        end
        if ($urandom_range(0, 99) < 85) begin
          if (s_odd) line_bytes.push_back(CH_SQUOTE);
          if (d_odd) line_bytes.push_back(CH_DQUOTE);
        end
      end else begin
        // Quoted word: sometimes empty, rarely left open on the last word.
        q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
        line_bytes.push_back(q);
        if (r >= 62) begin
          repeat ($urandom_range(1, 6)) begin
            do begin
              b = 8'($urandom_range(1, 255));
            end while (b == q);
            line_bytes.push_back(b);
          end
        end
        if (!(r >= 97 && w == nwords - 1)) line_bytes.push_back(q);
        glued = ($urandom_range(0, 9) < 3);
      end
      if (w == nwords - 1) begin
        if ($urandom_range(0, 2) == 0) add_blanks($urandom_range(1, 3));
      end else if (!glued) begin
        add_blanks($urandom_range(1, 3));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines: empty line, single word, glued quoted words with a top-bit byte,
    // empty quotes, unclosed quotes and plain words with odd or even quote counts.
    send_line(1'b0);
    add_text("a");
    send_line(1'b0);
    add_text("'x'\"y\"\t");
    line_bytes.push_back(8'hFF);
    add_text(" ");
    send_line(1'b1);
    add_text("''z");
    send_line(1'b0);
    add_text("\"\"");
    send_line(1'b0);
    add_text("'ab");
    send_line(1'b0);
    add_text("\"a");
    send_line(1'b0);
    add_text("a'\" ");
    send_line(1'b0);
    add_text("a\"");
    send_line(1'b0);
    add_text("a''b");
    send_line(1'b0);

    // Random lines, a quarter of them without any input gaps.
    while (bytes_sent < RANDOM_ITEMS) begin
      build_random_line();
      send_line($urandom_range(0, 3) == 0);
    end

    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
